// ===== src/qrfr_pkg.sv =====
`default_nettype none

package qrfr_pkg;

  // Field widths of the pixel and remap beats.
  localparam int COORD_W = 10;
  localparam int LEVEL_W = 4;
  localparam int STEP_W  = 5;
  localparam int ZONE_W  = 2;

  // Divisor width: level_log2 - 1 always fits the level field.
  localparam int DEN_W = LEVEL_W;

  localparam logic [COORD_W-1:0] COORD_MASK = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN  = 4'd2;

  // Zone codes, in rising order of priority.
  localparam logic [ZONE_W-1:0] ZONE_TL = 2'd0;
  localparam logic [ZONE_W-1:0] ZONE_TR = 2'd1;
  localparam logic [ZONE_W-1:0] ZONE_BL = 2'd2;
  localparam logic [ZONE_W-1:0] ZONE_BR = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [LEVEL_W-1:0] level_log2;
    logic [STEP_W-1:0]  step_index;
  } pixel_t;

  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic               moved;
    logic [ZONE_W-1:0]  zone;
  } remap_t;

  // Data that rides along the divider with each beat.
  typedef struct packed {
    logic               pass;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [DEN_W-1:0]   den;
    logic [1:0]         quo;
  } div_tag_t;

endpackage

`default_nettype wire

// ===== src/qrfr_frac_div.sv =====
`default_nettype none

module qrfr_frac_div #(
  parameter int STEPS  = 4,
  parameter int STAGES = 3
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [qrfr_pkg::DEN_W-1:0]  in_num,
  input  wire logic [qrfr_pkg::DEN_W-1:0]  in_den,
  input  wire qrfr_pkg::div_tag_t          in_tag,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [STEPS*STAGES-1:0]          out_frac,
  output qrfr_pkg::div_tag_t               out_tag
);

  import qrfr_pkg::*;

  localparam int FW = STEPS * STAGES;

  // Stage registers.
  logic             v    [STAGES];
  logic [DEN_W-1:0] rem  [STAGES];
  logic [DEN_W-1:0] den  [STAGES];
  logic [FW-1:0]    frac [STAGES];
  div_tag_t         tag  [STAGES];

  // What each stage sees at its input.
  logic             src_v    [STAGES];
  logic [DEN_W-1:0] src_rem  [STAGES];
  logic [DEN_W-1:0] src_den  [STAGES];
  logic [FW-1:0]    src_frac [STAGES];
  div_tag_t         src_tag  [STAGES];

  logic [DEN_W-1:0] rem_next  [STAGES];
  logic [FW-1:0]    frac_next [STAGES];

  logic rdy [STAGES+1];

  assign rdy[STAGES] = out_ready;
  assign in_ready    = rdy[0];

  assign src_v[0]    = in_valid;
  assign src_rem[0]  = in_num;
  assign src_den[0]  = in_den;
  assign src_frac[0] = '0;
  assign src_tag[0]  = in_tag;

  // Chain the stages and let each one take a beat when it is empty or moving on.
  for (genvar s = 0; s < STAGES; s++) begin : g_link
    if (s > 0) begin : g_src
      assign src_v[s]    = v[s-1];
      assign src_rem[s]  = rem[s-1];
      assign src_den[s]  = den[s-1];
      assign src_frac[s] = frac[s-1];
      assign src_tag[s]  = tag[s-1];
    end
    assign rdy[s] = !v[s] || rdy[s+1];
  end

  // Restoring division of the remainder, a few quotient bits per stage.
  always_comb begin
    logic [DEN_W-1:0] r;
    logic [DEN_W:0]   r2;
    logic             qb;
    logic [FW-1:0]    f;
    for (int s = 0; s < STAGES; s++) begin
      r = src_rem[s];
      f = src_frac[s];
      for (int i = 0; i < STEPS; i++) begin
        r2 = {r, 1'b0};
        qb = (r2 >= {1'b0, src_den[s]});
        r  = qb ? DEN_W'(r2 - {1'b0, src_den[s]}) : DEN_W'(r2);
        f  = {f[FW-2:0], qb};
      end
      rem_next[s]  = r;
      frac_next[s] = f;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STAGES; s++) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (rdy[s]) begin
        v[s] <= src_v[s];
      end
      if (rdy[s] && src_v[s]) begin
        rem[s]  <= rem_next[s];
        den[s]  <= src_den[s];
        frac[s] <= frac_next[s];
        tag[s]  <= src_tag[s];
      end
    end
  end

  assign out_valid = v[STAGES-1];
  assign out_frac  = frac[STAGES-1];
  assign out_tag   = tag[STAGES-1];

endmodule

`default_nettype wire

// ===== src/quadrant_rotation_frame_remap.sv =====
`default_nettype none

// Maps each output pixel of one quadrant-rotation animation frame to its source pixel in
// the level's base frame, taking one pixel beat per clock while nothing stalls and giving
// one remap beat per beat, in order. A beat passes through an input register that splits
// the step count into whole and leftover parts of the divisor, three stages of a pipelined
// fractional divider that works out the quadrant shift, one stage that assembles the
// shift, and the output register where the zone tests pick the source address. Every
// stage holds its own valid bit, so a stall at the output backs up only the stages that
// are full and empty stages keep filling. A level or step out of range, or a pixel outside
// the frame, comes back as its own address with moved clear and zone zero. There are no
// configuration registers and no state between beats.
module quadrant_rotation_frame_remap #(
  parameter int MAX_LOG2 = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pixel_valid,
  output logic                  pixel_stall,
  input  wire qrfr_pkg::pixel_t pixel,
  output logic                  remap_valid,
  input  wire logic             remap_stall,
  output qrfr_pkg::remap_t      remap
);

  import qrfr_pkg::*;

  // Fraction bits needed for the largest level, spread over the divider stages.
  localparam int DIV_STAGES = 3;
  localparam int FRAC_BITS  = MAX_LOG2 - 2;
  localparam int DIV_STEPS  = (FRAC_BITS < 1) ? 1 : (FRAC_BITS + DIV_STAGES - 1) / DIV_STAGES;
  localparam int FW         = DIV_STEPS * DIV_STAGES;
  localparam int SHW        = MAX_LOG2;
  localparam int UW         = MAX_LOG2 + 1;

  // Input decode: range checks and step count split by the divisor.
  logic             lvl_ok;
  logic             stp_ok;
  logic             pos_ok;
  logic [DEN_W-1:0] den_in;
  logic [STEP_W-1:0] frames;
  logic [STEP_W:0]  num0;
  logic [STEP_W:0]  num1;
  logic [STEP_W:0]  num2;
  logic [STEP_W:0]  den_wide;
  logic             sub0;
  logic             sub1;
  div_tag_t         tag_in;

  always_comb begin
    den_in   = pixel.level_log2 - 4'd1;
    frames   = {den_in, 1'b0};
    lvl_ok   = (pixel.level_log2 >= LEVEL_MIN) &&
               ({1'b0, pixel.level_log2} <= 5'(MAX_LOG2));
    stp_ok   = (pixel.step_index < frames);
    pos_ok   = ((pixel.pixel_x >> MAX_LOG2) == '0) && ((pixel.pixel_y >> MAX_LOG2) == '0);
    den_wide = {2'b00, den_in};
    num0     = {1'b0, pixel.step_index} + 6'd1;
    sub0     = (num0 >= den_wide);
    num1     = sub0 ? num0 - den_wide : num0;
    sub1     = (num1 >= den_wide);
    num2     = sub1 ? num1 - den_wide : num1;
    tag_in.pass = !(lvl_ok && stp_ok && pos_ok);
    tag_in.px   = pixel.pixel_x;
    tag_in.py   = pixel.pixel_y;
    tag_in.den  = den_in;
    tag_in.quo  = {1'b0, sub0} + {1'b0, sub1};
  end

  // Stage A: decoded beat.
  logic             a_v;
  div_tag_t         a_tag;
  logic [DEN_W-1:0] a_rem;
  logic             a_ready;
  logic             div_in_ready;

  assign a_ready     = !a_v || div_in_ready;
  assign pixel_stall = !a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (a_ready) begin
      a_v <= pixel_valid;
    end
    if (a_ready && pixel_valid) begin
      a_tag <= tag_in;
      a_rem <= DEN_W'(num2);
    end
  end

  // Fraction of the leftover over the divisor.
  logic          d_v;
  logic          b_ready;
  logic [FW-1:0] d_frac;
  div_tag_t      d_tag;

  qrfr_frac_div #(
    .STEPS  (DIV_STEPS),
    .STAGES (DIV_STAGES)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_v),
    .in_ready  (div_in_ready),
    .in_num    (a_rem),
    .in_den    (a_tag.den),
    .in_tag    (a_tag),
    .out_valid (d_v),
    .out_ready (b_ready),
    .out_frac  (d_frac),
    .out_tag   (d_tag)
  );

  // Stage B: shift = quotient * 2^(den-1) + fraction scaled to den-1 bits.
  logic [DEN_W-1:0] dm1;
  logic [4:0]       frac_sh;
  logic [SHW-1:0]   shift_next;
  logic             b_v;
  div_tag_t         b_tag;
  logic [SHW-1:0]   b_shift;
  logic             c_ready;

  always_comb begin
    dm1        = d_tag.den - 4'd1;
    frac_sh    = 5'(FW) - {1'b0, dm1};
    shift_next = (SHW'(d_tag.quo) << dm1) + SHW'(d_frac >> frac_sh);
  end

  assign b_ready = !b_v || c_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (b_ready) begin
      b_v <= d_v;
    end
    if (b_ready && d_v) begin
      b_tag   <= d_tag;
      b_shift <= shift_next;
    end
  end

  // Stage C: zone tests within the segment and source address.
  logic [4:0]         lvl_sh;
  logic [COORD_W-1:0] seg_mask;
  logic [UW-1:0]      rx;
  logic [UW-1:0]      ry;
  logic [UW-1:0]      half;
  logic [UW-1:0]      full;
  logic [UW-1:0]      sh_u;
  logic [UW-1:0]      h_less;
  logic [UW-1:0]      h_more;
  logic [UW-1:0]      f_less;
  logic [COORD_W-1:0] sh_c;
  logic               z0;
  logic               z1;
  logic               z2;
  logic               z3;
  remap_t             remap_next;

  always_comb begin
    lvl_sh   = {1'b0, b_tag.den} + 5'd1;
    seg_mask = ~(COORD_MASK << lvl_sh);
    rx       = UW'(b_tag.px & seg_mask);
    ry       = UW'(b_tag.py & seg_mask);
    half     = UW'(1) << b_tag.den;
    full     = half + half;
    sh_u     = UW'(b_shift);
    h_less   = half - sh_u;
    h_more   = half + sh_u;
    f_less   = full - sh_u;
    sh_c     = COORD_W'(b_shift);
    z0 = (rx >= sh_u) && (rx < h_more) && (ry < half);
    z1 = (rx >= half) && (rx < full) && (ry >= sh_u) && (ry < h_more);
    z2 = (rx < half) && (ry >= h_less) && (ry < f_less);
    z3 = (rx >= h_less) && (rx < f_less) && (ry >= half) && (ry < full);

    remap_next.src_x = b_tag.px;
    remap_next.src_y = b_tag.py;
    remap_next.moved = 1'b0;
    remap_next.zone  = ZONE_TL;
    if (!b_tag.pass) begin
      if (z3) begin
        remap_next.src_x = b_tag.px + sh_c;
        remap_next.moved = 1'b1;
        remap_next.zone  = ZONE_BR;
      end else if (z2) begin
        remap_next.src_y = b_tag.py + sh_c;
        remap_next.moved = 1'b1;
        remap_next.zone  = ZONE_BL;
      end else if (z1) begin
        remap_next.src_y = b_tag.py - sh_c;
        remap_next.moved = 1'b1;
        remap_next.zone  = ZONE_TR;
      end else if (z0) begin
        remap_next.src_x = b_tag.px - sh_c;
        remap_next.moved = 1'b1;
        remap_next.zone  = ZONE_TL;
      end
    end
  end

  assign c_ready = !remap_valid || !remap_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      remap_valid <= 1'b0;
    end else if (c_ready) begin
      remap_valid <= b_v;
    end
    if (c_ready && b_v) begin
      remap <= remap_next;
    end
  end

  // The split of the step count leaves a remainder below the divisor.
  assert property (@(posedge clk) disable iff (rst)
    (a_v && !a_tag.pass) |-> (a_rem < a_tag.den))
    else $error("leftover step count not below divisor");

  // The assembled shift never moves a quadrant by more than its own width.
  assert property (@(posedge clk) disable iff (rst)
    (b_v && !b_tag.pass) |-> (sh_u <= half))
    else $error("quadrant shift exceeds half segment width");

  // An accepted pixel beat always lands in the first stage.
  assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_stall) |=> a_v)
    else $error("accepted beat lost at pipeline entry");

endmodule

`default_nettype wire
